### design/cist_pkg.sv
package cist_pkg;

  localparam int SLOT_COUNT_DEF = 16;
  localparam int KEY_BITS_DEF   = 8;
  localparam int CNT_BITS       = 8;

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  // Result of the shared key compare / count arithmetic unit
  typedef struct packed {
    logic                match;
    logic                under;
    logic                zero;
    logic [CNT_BITS-1:0] sum;
    logic [CNT_BITS-1:0] diff;
  } alu_res_t;

endpackage

### design/cist_ram.sv
module cist_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/cist_alu.sv
module cist_alu
  import cist_pkg::*;
#(
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic [KEY_BITS-1:0] key_a,
  input  logic [KEY_BITS-1:0] key_b,
  input  logic [CNT_BITS-1:0] cnt,
  input  logic [CNT_BITS-1:0] amt,
  output alu_res_t            res
);

  always_comb begin
    res.match = (key_a == key_b);
    res.under = (cnt < amt);
    res.sum   = cnt + amt;
    res.diff  = cnt - amt;
    res.zero  = (cnt == amt);
  end

endmodule

### design/counted_item_slot_table_unit.sv
// Sequence: the beat is latched on accept, then S slots are scanned (match index + 1, slots
//   in use when absent, 0 on an empty table), the result is formed in S_EXEC and, on a
//   delete, H later slots are moved down; S + H never exceeds the slots in use. One slot
//   read per cycle on the RAM port.
// Throughput: one request at a time; busy drops in the cycle the result is on the outputs,
//   so a new beat can go in once busy is low. Results pulse on out_valid for one cycle.
// Reset (synchronous, rst_n low) empties the table at once; slot storage is not cleared.
module counted_item_slot_table_unit
  import cist_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_req_type,
  input  logic [7:0] in_item_key,
  input  logic [7:0] in_amount,
  output logic       out_valid,
  output logic       out_success,
  output logic [7:0] out_key_count,
  output logic [4:0] out_slots_used
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int IW    = CNT_W + 1;
  localparam int DW    = KEY_BITS + CNT_BITS;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;
  localparam logic [1:0] S_SHIFT = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [IDX_W-1:0]    pos_r, pos_nxt;
  logic                found_r, found_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [1:0]          req_r, req_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [CNT_BITS-1:0] amt_r, amt_nxt;
  logic [CNT_W-1:0]    used_r, used_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_success_r, out_success_nxt;
  logic [CNT_BITS-1:0] out_key_count_r, out_key_count_nxt;
  logic [CNT_W-1:0]    out_used_r, out_used_nxt;

  // RAM port signals
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [DW-1:0]    ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [DW-1:0]    ram_rdata;

  logic [KEY_BITS-1:0] rd_key;
  logic [CNT_BITS-1:0] rd_cnt;
  alu_res_t            alu;

  logic [IW-1:0] idx_p1, idx_p2, pos_p1, used_w;

  assign rd_key = ram_rdata[DW-1:CNT_BITS];
  assign rd_cnt = ram_rdata[CNT_BITS-1:0];

  assign idx_p1 = IW'(idx_r) + IW'(1);
  assign idx_p2 = IW'(idx_r) + IW'(2);
  assign pos_p1 = IW'(pos_r) + IW'(1);
  assign used_w = IW'(used_r);

  cist_ram #(
    .WIDTH (DW),
    .DEPTH (SLOT_COUNT)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared unit: key compare while scanning, count add / subtract when executing
  cist_alu #(
    .KEY_BITS (KEY_BITS)
  ) u_alu (
    .key_a (key_r),
    .key_b (rd_key),
    .cnt   (cnt_r),
    .amt   (amt_r),
    .res   (alu)
  );

  // Read address runs one slot ahead of the state that consumes the data
  always_comb begin
    unique case (state_r)
      S_IDLE:  ram_raddr = '0;
      S_SCAN:  ram_raddr = IDX_W'(idx_p1);
      S_EXEC:  ram_raddr = IDX_W'(pos_p1);
      S_SHIFT: ram_raddr = IDX_W'(idx_p2);
      default: ram_raddr = '0;
    endcase
  end

  always_comb begin
    state_nxt         = state_r;
    idx_nxt           = idx_r;
    pos_nxt           = pos_r;
    found_nxt         = found_r;
    cnt_nxt           = cnt_r;
    req_nxt           = req_r;
    key_nxt           = key_r;
    amt_nxt           = amt_r;
    used_nxt          = used_r;
    out_valid_nxt     = 1'b0;
    out_success_nxt   = out_success_r;
    out_key_count_nxt = out_key_count_r;
    out_used_nxt      = out_used_r;
    ram_we            = 1'b0;
    ram_waddr         = pos_r;
    ram_wdata         = {key_r, alu.sum};

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          // Latch the beat and start the scan at slot 0
          req_nxt   = in_req_type;
          key_nxt   = KEY_BITS'(in_item_key);
          amt_nxt   = in_amount;
          found_nxt = 1'b0;
          cnt_nxt   = '0;
          idx_nxt   = '0;
          state_nxt = (used_r == '0) ? S_EXEC : S_SCAN;
        end
      end

      S_SCAN: begin
        // Data on the RAM port belongs to slot idx_r
        if (alu.match) begin
          found_nxt = 1'b1;
          pos_nxt   = idx_r;
          cnt_nxt   = rd_cnt;
          state_nxt = S_EXEC;
        end else if (idx_p1 == used_w) begin
          state_nxt = S_EXEC;
        end else begin
          idx_nxt = IDX_W'(idx_p1);
        end
      end

      S_EXEC: begin
        state_nxt         = S_IDLE;
        out_valid_nxt     = 1'b1;
        out_success_nxt   = 1'b0;
        out_key_count_nxt = found_r ? cnt_r : '0;
        priority case (req_r)
          REQ_ADD: begin
            if (found_r) begin
              ram_we            = 1'b1;
              ram_wdata         = {key_r, alu.sum};
              out_success_nxt   = 1'b1;
              out_key_count_nxt = alu.sum;
            end else if (used_w < IW'(SLOT_COUNT)) begin
              // Append a new slot at the end
              ram_we            = 1'b1;
              ram_waddr         = IDX_W'(used_r);
              ram_wdata         = {key_r, amt_r};
              used_nxt          = used_r + CNT_W'(1);
              out_success_nxt   = 1'b1;
              out_key_count_nxt = amt_r;
            end
          end
          REQ_REMOVE: begin
            if (found_r && !alu.under) begin
              out_success_nxt   = 1'b1;
              out_key_count_nxt = alu.diff;
              if (!alu.zero) begin
                ram_we    = 1'b1;
                ram_wdata = {key_r, alu.diff};
              end else if (pos_p1 < used_w) begin
                // Delete: move the later slots down, one per cycle
                idx_nxt       = pos_r;
                state_nxt     = S_SHIFT;
                out_valid_nxt = 1'b0;
              end else begin
                used_nxt = used_r - CNT_W'(1);
              end
            end
          end
          REQ_QUERY: begin
            out_success_nxt = 1'b1;
          end
          default: begin
            out_success_nxt = 1'b0;
          end
        endcase
        out_used_nxt = used_nxt;
      end

      S_SHIFT: begin
        // Data on the RAM port belongs to slot idx_r + 1
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = ram_rdata;
        if (idx_p2 < used_w) begin
          idx_nxt = IDX_W'(idx_p1);
        end else begin
          used_nxt          = used_r - CNT_W'(1);
          state_nxt         = S_IDLE;
          out_valid_nxt     = 1'b1;
          out_success_nxt   = 1'b1;
          out_key_count_nxt = '0;
          out_used_nxt      = used_r - CNT_W'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers hold without reset
  always_ff @(posedge clk) begin
    idx_r           <= idx_nxt;
    pos_r           <= pos_nxt;
    cnt_r           <= cnt_nxt;
    req_r           <= req_nxt;
    key_r           <= key_nxt;
    amt_r           <= amt_nxt;
    out_success_r   <= out_success_nxt;
    out_key_count_r <= out_key_count_nxt;
    out_used_r      <= out_used_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_success    = out_success_r;
  assign out_key_count  = out_key_count_r;
  assign out_slots_used = 5'(out_used_r);

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    IW'(used_r) <= IW'(SLOT_COUNT))
    else $error("slot fill count exceeds table size");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (idx_p1 <= used_w))
    else $error("scan index past occupied slots");

  a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (idx_p2 <= used_w))
    else $error("compaction index past occupied slots");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a request in progress");

  a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

endmodule
